@@ rtl/voter_model_ring_update_defines.svh @@
// ---------------------------------------------------------------------------
// Voter model ring update: assertion macros
// Shorthand for the clocked, reset-qualified checks used in the top level.
// ---------------------------------------------------------------------------
`ifndef VOTER_MODEL_RING_UPDATE_DEFINES_SVH
`define VOTER_MODEL_RING_UPDATE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define VMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define VMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vmr_pkg.sv @@
// ---------------------------------------------------------------------------
// vmr_pkg
// Types and fixed constants shared by the voter model ring update block.
// ---------------------------------------------------------------------------
package vmr_pkg;

  localparam int SITE_W    = 10;
  localparam int CNT_W     = 11;
  localparam int SWEEP_W   = 32;
  localparam int SAMPLE_W  = 16;
  localparam int THR_W     = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_THRESHOLD = 1'd1;

  // Register reset values
  localparam logic [CNT_W-1:0] RING_SIZE_RST = 11'd1024;
  localparam logic [THR_W-1:0] THR_RST       = 17'd32768;

  // Smallest usable ring
  localparam logic [CNT_W-1:0] MIN_N = 11'd2;

  // Item opcodes and directions
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;
  localparam logic DIR_LEFT  = 1'b0;
  localparam logic DIR_RIGHT = 1'b1;

  typedef struct packed {
    logic                op;
    logic [SITE_W-1:0]   site;
    logic                direction;
    logic [SAMPLE_W-1:0] random_sample;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   positive_count;
    logic [SWEEP_W-1:0] sweep_count;
    logic               sweep_done;
    logic               consensus;
    logic               all_positive;
  } out_item_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_COMMIT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic accept;   // latch item, read both ring bits
    logic commit;   // update counters, write ring, load result
  } ctrl_t;

  // Datapath -> controller
  typedef struct packed {
    logic out_free; // result register can take a new item
  } status_t;

endpackage

@@ rtl/vmr_ctrl.sv @@
// ---------------------------------------------------------------------------
// vmr_ctrl
// Two-state sequencer: accept and read, then commit when the result slot frees.
// ---------------------------------------------------------------------------
module vmr_ctrl import vmr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output ctrl_t   ctrl
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ctrl.accept = 1'b0;
    ctrl.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctrl.accept = in_valid;
      end
      ST_COMMIT: begin
        ctrl.commit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/vmr_datapath.sv @@
// ---------------------------------------------------------------------------
// vmr_datapath
// Config registers, opinion memory, run counters and the result register.
// ---------------------------------------------------------------------------
module vmr_datapath import vmr_pkg::*; #(
  parameter int MAX_SITES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  in_item_t             in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  ctrl_t                ctrl,
  output status_t              status
);

  localparam int AW        = (MAX_SITES > 2) ? $clog2(MAX_SITES) : 1;
  localparam int MAX_N_INT = (MAX_SITES > 2047) ? 2047 : MAX_SITES;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_N_INT);
  localparam int XW        = (AW > CNT_W) ? AW : CNT_W;

  // Config
  logic [CNT_W-1:0] ring_size_r;
  logic [THR_W-1:0] thr_r;
  logic [CNT_W-1:0] n;

  // Accept side
  logic [CNT_W-1:0] in_site;
  logic [CNT_W-1:0] in_plus;
  logic [CNT_W-1:0] in_nb;
  logic [XW-1:0]    site_x;
  logic [XW-1:0]    nb_x;
  logic [AW-1:0]    rd_addr_a;
  logic [AW-1:0]    rd_addr_b;

  // Item and read data
  in_item_t         item_r;
  logic [AW-1:0]    nb_r;
  logic             src_r;
  logic             dst_r;
  logic             mem [MAX_SITES];

  // Commit side
  logic [CNT_W-1:0]   site_c;
  logic [XW-1:0]      site_cx;
  logic               in_range;
  logic               bit_c;
  logic [CNT_W-1:0]   base_pos;
  logic [CNT_W-1:0]   upd_inc;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               wr_data;
  logic               done;
  logic               agree;

  // Counters
  logic [CNT_W-1:0]   pos_r;
  logic [CNT_W-1:0]   pos_nxt;
  logic [CNT_W-1:0]   upd_r;
  logic [CNT_W-1:0]   upd_nxt;
  logic [SWEEP_W-1:0] sweeps_r;
  logic [SWEEP_W-1:0] sweeps_nxt;

  logic               out_valid_r;
  out_item_t          out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r <= RING_SIZE_RST;
      thr_r       <= THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RING_SIZE:      ring_size_r <= cfg_wdata[CNT_W-1:0];
        REG_INIT_THRESHOLD: thr_r       <= cfg_wdata[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamped ring size
  always_comb begin
    if (ring_size_r < MIN_N) begin
      n = MIN_N;
    end else if (ring_size_r > MAX_N) begin
      n = MAX_N;
    end else begin
      n = ring_size_r;
    end
  end

  // Neighbor address with wrap
  always_comb begin
    in_site = {1'b0, in_data.site};
    in_plus = in_site + CNT_W'(1);
    if (in_data.direction == DIR_RIGHT) begin
      in_nb = (in_plus >= n) ? '0 : in_plus;
    end else begin
      in_nb = (in_site == '0) ? (n - CNT_W'(1)) : (in_site - CNT_W'(1));
    end
    site_x    = XW'(in_site);
    nb_x      = XW'(in_nb);
    rd_addr_a = site_x[AW-1:0];
    rd_addr_b = nb_x[AW-1:0];
  end

  // Opinion memory: two registered reads on accept, one write on commit
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      src_r  <= mem[rd_addr_a];
      dst_r  <= mem[rd_addr_b];
      item_r <= in_data;
      nb_r   <= rd_addr_b;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    site_c     = {1'b0, item_r.site};
    site_cx    = XW'(site_c);
    in_range   = (site_c < n);
    bit_c      = ({1'b0, item_r.random_sample} < thr_r);
    base_pos   = pos_r;
    upd_inc    = upd_r + CNT_W'(1);
    pos_nxt    = pos_r;
    upd_nxt    = upd_r;
    sweeps_nxt = sweeps_r;
    done       = 1'b0;
    agree      = 1'b0;
    wr_addr    = site_cx[AW-1:0];
    wr_data    = bit_c;
    if (in_range) begin
      if (item_r.op == OP_LOAD) begin
        // Site 0 starts a new run
        if (site_c == '0) begin
          base_pos   = '0;
          upd_nxt    = '0;
          sweeps_nxt = '0;
        end
        pos_nxt = (bit_c && (base_pos < n)) ? (base_pos + CNT_W'(1)) : base_pos;
      end else begin
        wr_addr = nb_r;
        wr_data = src_r;
        if (src_r && !dst_r && (pos_r < n)) begin
          pos_nxt = pos_r + CNT_W'(1);
        end else if (!src_r && dst_r && (pos_r != '0)) begin
          pos_nxt = pos_r - CNT_W'(1);
        end
        if (upd_inc >= n) begin
          upd_nxt    = '0;
          sweeps_nxt = (sweeps_r != '1) ? (sweeps_r + SWEEP_W'(1)) : sweeps_r;
          done       = 1'b1;
          agree      = (pos_nxt == '0) || (pos_nxt == n);
        end else begin
          upd_nxt = upd_inc;
        end
      end
    end
    wr_en = ctrl.commit && in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      upd_r    <= '0;
      sweeps_r <= '0;
    end else if (ctrl.commit) begin
      pos_r    <= pos_nxt;
      upd_r    <= upd_nxt;
      sweeps_r <= sweeps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      out_data_r.positive_count <= pos_nxt;
      out_data_r.sweep_count    <= sweeps_nxt;
      out_data_r.sweep_done     <= done;
      out_data_r.consensus      <= agree;
      out_data_r.all_positive   <= (pos_nxt == n);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

@@ rtl/voter_model_ring_update.sv @@
// ---------------------------------------------------------------------------
// voter_model_ring_update
// One-dimensional ring voter model: site loads and neighbor-copy updates.
// ---------------------------------------------------------------------------
// Each item is accepted (item latched, site and neighbor opinion bits read
// from the single opinion memory, registered) and then committed (counters
// adjusted, copied bit written back, result register loaded). Commit waits
// while the result register still holds an untaken item, so a new item is
// accepted as soon as the previous one has committed, even if its result is
// still pending. Load items set a site to 1 when random_sample <
// init_threshold; loading site 0 clears the positive count, the update
// counter and the sweep counter. Update items copy the site's opinion onto
// its left or right neighbor (ring wraps) and report a sweep after every
// ring_size updates. ring_size is clamped to 2..min(MAX_SITES, 2047). Sites
// at or beyond the ring size change nothing. Opinions have no reset: every
// site in use must be loaded before an update reads it. Configuration writes
// take effect at once; the user must make them only while idle (unenforced).
// ---------------------------------------------------------------------------
`include "voter_model_ring_update_defines.svh"

module voter_model_ring_update import vmr_pkg::*; #(
  parameter int MAX_SITES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // Input item channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // Result item channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  ctrl_t   ctrl;
  status_t status;

  // Sequencer: idle/accept, then commit
  vmr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // Opinion memory, counters, result register
  vmr_datapath #(
    .MAX_SITES (MAX_SITES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ctrl      (ctrl),
    .status    (status)
  );

  // Accept and commit never overlap; one item in flight at a time
  `VMR_ASSERT_NOW(a_accept_commit_excl, ctrl.accept, !ctrl.commit, "accept during commit")
  // After an accept the block is busy for the commit cycle
  `VMR_ASSERT_NEXT(a_busy_after_accept, ctrl.accept, !in_ready, "ready right after accept")
  // A commit always presents a result
  `VMR_ASSERT_NEXT(a_commit_result, ctrl.commit, out_valid, "commit without result")
  // Consensus is reported only at a sweep end
  `VMR_ASSERT_NOW(a_consensus_sweep, out_valid && out_data.consensus,
                  out_data.sweep_done, "consensus without sweep end")

endmodule

@@ bench/voter_ring_check_pkg.sv @@
// ----------------------------------------------------------------------------
// Voter ring checker
// Tracks the ring opinions, the positive count and the sweep counters, and
// compares every result of the voter model ring block against that tracking.
// ----------------------------------------------------------------------------
package voter_ring_check_pkg;
  import vmr_pkg::*;

  localparam int unsigned RING_SITES = 1024;

  class voter_ring_checker;
    logic [CNT_W-1:0]   ring_size_reg;
    logic [THR_W-1:0]   threshold_reg;
    bit                 opinion [RING_SITES];
    int unsigned        positives;
    int unsigned        updates_done;
    logic [SWEEP_W-1:0] sweeps_done;
    out_item_t          expected_reports[$];
    int unsigned        errors;
    int unsigned        seen;

    function new();
      ring_size_reg = RING_SIZE_RST;
      threshold_reg = THR_RST;
      positives     = 0;
      updates_done  = 0;
      sweeps_done   = '0;
      errors        = 0;
      seen          = 0;
      foreach (opinion[i]) opinion[i] = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_RING_SIZE) ring_size_reg = data[CNT_W-1:0];
      else if (idx == REG_INIT_THRESHOLD) threshold_reg = data[THR_W-1:0];
    endfunction

    // Ring size as the block uses it: clamped to 2..RING_SITES.
    function int unsigned sites_in_use();
      int unsigned n;
      n = 32'(ring_size_reg);
      if (n < 32'(MIN_N)) n = 32'(MIN_N);
      if (n > RING_SITES) n = RING_SITES;
      return n;
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction

    // Called at the edge where an item is taken by the block.
    function void take_item(in_item_t it);
      out_item_t   r;
      int unsigned n;
      int unsigned site;
      int unsigned nb;
      bit          src;
      bit          dst;
      bit          pick;
      n    = sites_in_use();
      site = 32'(it.site);
      r    = '0;
      if (site < n) begin
        if (it.op == OP_LOAD) begin
          pick = (it.random_sample < threshold_reg);
          if (site == 0) begin
            positives    = 0;
            updates_done = 0;
            sweeps_done  = '0;
          end
          opinion[site] = pick;
          if (pick && positives < n) positives++;
        end else begin
          if (it.direction == DIR_RIGHT) nb = (site + 1 >= n) ? 0 : site + 1;
          else nb = (site == 0) ? n - 1 : site - 1;
          src = opinion[site];
          dst = opinion[nb];
          if (src && !dst) begin
            if (positives < n) positives++;
          end else if (!src && dst) begin
            if (positives > 0) positives--;
          end
          opinion[nb] = src;
          updates_done++;
          if (updates_done >= n) begin
            updates_done = 0;
            if (sweeps_done != '1) sweeps_done++;
            r.sweep_done = 1'b1;
            r.consensus  = (positives == 0) || (positives == n);
          end
        end
      end
      r.positive_count = CNT_W'(positives);
      r.sweep_count    = sweeps_done;
      r.all_positive   = (positives == n);
      expected_reports.push_back(r);
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      seen++;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: result %0d with nothing expected: %s",
                   seen, $sformatf("cnt=%0d sweeps=%0d done=%b cons=%b all=%b",
                   got.positive_count, got.sweep_count, got.sweep_done,
                   got.consensus, got.all_positive));
        return;
      end
      want = expected_reports.pop_front();
      if (got.positive_count !== want.positive_count ||
          got.sweep_count    !== want.sweep_count    ||
          got.sweep_done     !== want.sweep_done     ||
          got.consensus      !== want.consensus      ||
          got.all_positive   !== want.all_positive) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: result %0d mismatch", seen);
          $display("  expected cnt=%0d sweeps=%0d done=%b cons=%b all=%b",
                   want.positive_count, want.sweep_count, want.sweep_done,
                   want.consensus, want.all_positive);
          $display("  actual   cnt=%0d sweeps=%0d done=%b cons=%b all=%b",
                   got.positive_count, got.sweep_count, got.sweep_done,
                   got.consensus, got.all_positive);
        end
      end
    endfunction
  endclass

endpackage

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Voter model ring update testbench
// Drives load and neighbor-copy items with random gaps on both channels,
// rewrites ring size and threshold between runs, and checks each result
// against a running model of the ring held in voter_ring_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vmr_pkg::*;
  import voter_ring_check_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;

  voter_ring_checker census = new();

  // Stimulus-side view of the ring: which sites hold a written opinion, and
  // the clamped ring size currently programmed.
  bit          loaded [RING_SITES];
  int unsigned cur_n;
  int unsigned live_items;   // items with an in-range site
  int unsigned in_calm;
  int unsigned out_calm;
  int unsigned cycle_count;

  voter_model_ring_update #(.MAX_SITES(RING_SITES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Results are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) census.check_report(out_data);
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  // with no gaps at all.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver: stall for a random gap, then hold ready high until the next gap.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = pick_gap(out_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Entered and left at a falling edge. Valid stays high across back-to-back
  // items; it only drops when a gap is inserted or when settle() runs.
  task automatic push_item(input in_item_t it);
    int unsigned gap;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    census.take_item(it);
    @(negedge clk);
  endtask

  task automatic send(input logic op, input int unsigned site, input logic dir,
                      input int unsigned sample);
    in_item_t it;
    it.op            = op;
    it.site          = SITE_W'(site);
    it.direction     = dir;
    it.random_sample = SAMPLE_W'(sample);
    if (site < cur_n) begin
      live_items++;
      if (op == OP_LOAD) loaded[site] = 1'b1;
    end
    push_item(it);
  endtask

  // Drop valid, wait until every result is back, then idle on so the next
  // valid rise never shares a step with this fall.
  task automatic settle();
    in_valid <= 1'b0;
    while (census.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Both registers, back to back, while the block is idle.
  task automatic apply_settings(input int unsigned ring, input int unsigned thr);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_RING_SIZE;
    cfg_wdata <= CFG_W'(ring);
    census.write_reg(REG_RING_SIZE, CFG_W'(ring));
    @(negedge clk);
    cfg_index <= REG_INIT_THRESHOLD;
    cfg_wdata <= CFG_W'(thr);
    census.write_reg(REG_INIT_THRESHOLD, CFG_W'(thr));
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_n = census.sites_in_use();
  endtask

  // An in-range update may only read sites that hold a written opinion.
  function automatic bit update_ok(input int unsigned site, input logic dir);
    int unsigned nb;
    if (dir == DIR_RIGHT) nb = (site + 1 >= cur_n) ? 0 : site + 1;
    else nb = (site == 0) ? cur_n - 1 : site - 1;
    return loaded[site] && loaded[nb];
  endfunction

  function automatic int unsigned pick_ring();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8)  return $urandom_range(0, 1);       // clamps up to 2
    if (r < 70) return $urandom_range(2, 16);
    if (r < 88) return $urandom_range(17, 64);
    if (r < 94) return RING_SITES;
    if (r < 97) return $urandom_range(1025, 2047); // clamps down
    return $urandom_range(65, 1023);
  endfunction

  function automatic int unsigned pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;                          // all zeros
    if (r < 30) return 65536;                      // all ones
    if (r < 35) return 131071;
    if (r < 45) return 32768;
    return $urandom_range(0, 131071);
  endfunction

  // Big rings: keep most traffic near both ends so the wrap gets exercised
  // without loading the whole ring.
  function automatic int unsigned pick_site();
    int unsigned r;
    if (cur_n <= 64) return $urandom_range(0, cur_n - 1);
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 7);
    if (r < 80) return cur_n - 1 - $urandom_range(0, 7);
    return $urandom_range(0, cur_n - 1);
  endfunction

  // Occasional disturbance inside a run: out-of-range sites, repeated
  // loads, and a restart through site 0.
  task automatic maybe_noise();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6 && cur_n < RING_SITES)
      send(1'($urandom_range(0, 1)), $urandom_range(cur_n, RING_SITES - 1),
           1'($urandom_range(0, 1)), $urandom_range(0, 65535));
    else if (r < 9)
      send(OP_LOAD, pick_site(), 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
    else if (r == 9)
      send(OP_LOAD, 0, 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
  endtask

  // One run: load the ring (small rings in order from site 0, big ones at site 0
  // only), then a stream of neighbor copies.
  task automatic run_phase();
    int unsigned steps;
    int unsigned site;
    logic        dir;
    if (cur_n <= 64) begin
      for (int unsigned k = 0; k < cur_n; k++) begin
        maybe_noise();
        send(OP_LOAD, k, 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
      end
      steps = $urandom_range(2 * cur_n, 5 * cur_n);
      if (steps > 60) steps = 60;
    end else begin
      send(OP_LOAD, 0, 1'($urandom_range(0, 1)), $urandom_range(0, 65535));
      steps = 80;
    end
    repeat (steps) begin
      maybe_noise();
      site = pick_site();
      dir  = 1'($urandom_range(0, 1));
      if (update_ok(site, dir))
        send(OP_UPDATE, site, dir, $urandom_range(0, 65535));
      else
        send(OP_LOAD, site, dir, $urandom_range(0, 65535));
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_RING_SIZE;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    cur_n      = 32'(RING_SIZE_RST);
    live_items = 0;
    in_calm    = 0;
    out_calm   = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset settings: threshold boundary and wrap both ways.
    send(OP_LOAD, 0, DIR_LEFT, 0);              // lowest sample -> 1
    send(OP_LOAD, RING_SITES - 1, DIR_RIGHT, 65535);
    send(OP_LOAD, 1, DIR_LEFT, 32767);          // just below threshold
    send(OP_LOAD, 2, DIR_RIGHT, 32768);         // at threshold -> 0
    send(OP_UPDATE, RING_SITES - 1, DIR_RIGHT, 0);  // last site onto site 0
    send(OP_UPDATE, 0, DIR_LEFT, 65535);            // site 0 onto last site
    send(OP_UPDATE, 1, DIR_LEFT, 1);

    // Ring size 0 acts as 2; the update counter already passed it, so the
    // next update closes a sweep. Threshold all ones.
    apply_settings(0, 131071);
    send(OP_UPDATE, 1, DIR_RIGHT, 0);
    send(OP_LOAD, 1, DIR_LEFT, 0);              // repeated load, count saturates
    send(OP_UPDATE, 2, DIR_LEFT, 65535);        // out of range
    send(OP_LOAD, RING_SITES - 1, DIR_RIGHT, 4660);

    // Threshold 0: zeros loaded without lowering the count, then the count
    // pinned at the top and at the bottom.
    apply_settings(1, 0);
    send(OP_LOAD, 1, DIR_RIGHT, 65535);
    send(OP_UPDATE, 0, DIR_RIGHT, 0);
    send(OP_LOAD, 0, DIR_LEFT, 12345);          // restart clears counters
    send(OP_UPDATE, 0, DIR_RIGHT, 43690);
    send(OP_UPDATE, 1, DIR_LEFT, 21845);

    // Oversized ring clamps to the full ring; wrap at the top end.
    apply_settings(2047, 65536);
    send(OP_LOAD, RING_SITES - 2, DIR_LEFT, 65535);
    send(OP_UPDATE, RING_SITES - 2, DIR_RIGHT, 0);
    send(OP_UPDATE, RING_SITES - 1, DIR_RIGHT, 65535);
    send(OP_LOAD, 512, DIR_RIGHT, 1);

    // Random runs until enough in-range items have gone through.
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      apply_settings(pick_ring(), pick_threshold());
      run_phase();
    end

    settle();
    repeat (20) @(negedge clk);
    if (census.errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule

@@ voter_model_ring_update.f @@
+incdir+rtl
rtl/vmr_pkg.sv
rtl/vmr_ctrl.sv
rtl/vmr_datapath.sv
rtl/voter_model_ring_update.sv
bench/voter_ring_check_pkg.sv
bench/tb.sv
